/* rtl/bfha_pkg.sv */
`timescale 1ns / 1ps
package bfha_pkg;

  // Field widths of the stream items and the configuration register
  localparam int CMD_W   = 2;
  localparam int REQ_W   = 15;
  localparam int BLK_W   = 14;
  localparam int ST_W    = 2;
  localparam int SIZE_W  = 15;
  localparam int RES_W   = 14;
  localparam int CFG_W   = 15;
  localparam int HEAP_FLOOR = 4096;
  localparam logic [CFG_W-1:0] CFG_RESET = 15'd4096;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FAIL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Per-cell control of the free list ring
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

/* rtl/best_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// Best-fit heap allocator over a byte heap addressed by offsets. Input items carry the
// command in s_axis_tuser and the request size and block offset in s_axis_tdata; each item
// gives exactly one result (status and payload offset) on the master side. Free chunk
// offsets sit in a ring of LIST_DEPTH cells kept in address order; chunk sizes live in a
// RAM of HEAP_BYTES/4 entries. An allocate or free rotates the ring once for the scan,
// with one RAM size read per cell, takes its decision and, when the list changes, rotates
// the ring once more for the edit, then does the size writes. Init goes straight to the
// size writes, and a request rejected at once goes straight to the result. Both stores
// start undefined, so there is no clearing pass after reset. A new item is taken while a
// result waits on the output.
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int HEAP_BYTES      = 16384,
  parameter int MIN_SPLIT_BYTES = 32,
  parameter int HEADER_BYTES    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // request_size [14:0], block_offset [28:15], zero fill [31:29]
  input  logic [31:0]      s_axis_tdata,
  // command [1:0]
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status [1:0], result_offset [15:2]
  output logic [15:0]      m_axis_tdata
);

  localparam int STORE_DEPTH = HEAP_BYTES / 4;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int LIST_DEPTH  = HEAP_BYTES / MIN_SPLIT_BYTES;
  localparam int CW          = $clog2(LIST_DEPTH + 1);
  localparam int TW          = $clog2(LIST_DEPTH);
  localparam int OW          = $clog2(HEAP_BYTES) + 3;
  localparam int HSW         = $clog2(HEAP_BYTES) + 1;
  localparam int NW          = REQ_W + 1;
  localparam int CAP         = (HEAP_BYTES / 4) * 4;

  typedef enum logic [2:0] {
    S_IDLE, S_SZRD, S_SCAN, S_DECIDE, S_EDIT, S_WR1, S_WR2, S_FIN
  } state_e;

  typedef enum logic [1:0] {ED_NONE, ED_REPL, ED_REM, ED_INS} edit_e;
  typedef enum logic [1:0] {FD_NONE, FD_PREV, FD_NEXT, FD_INS} fdec_e;

  state_e            state_q;
  edit_e             edit_q;
  fdec_e             dec_q;
  logic [CFG_W-1:0]  heap_bytes_q;
  logic [HSW-1:0]    heap_size_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     step_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [NW-1:0]     need_q;
  logic [SIZE_W-1:0] best_q;
  logic [TW-1:0]     t_q;
  logic [OW-1:0]     val_q;
  logic [OW-1:0]     boff_q;
  logic [OW-1:0]     chunk_q;
  logic [SIZE_W-1:0] csz_q;
  logic [SIZE_W-1:0] cs_q;
  logic [SIZE_W-1:0] send_q;
  logic              mnext_q;
  logic              cap_q;
  logic [OW-1:0]     dly_q;
  logic              rd_oob_q;
  logic [OW-1:0]     prev_q;
  logic [OW-1:0]     prev2_q;
  logic              wr1_en_q, wr2_en_q;
  logic [AW-1:0]     wr1_addr_q, wr2_addr_q;
  logic [SIZE_W-1:0] wr1_data_q, wr2_data_q;
  logic [ST_W-1:0]   status_q;
  logic [RES_W-1:0]  pay_q;
  logic              out_valid_q;
  logic [ST_W-1:0]   out_status_q;
  logic [RES_W-1:0]  out_pay_q;

  // Input fields
  logic [CMD_W-1:0] in_cmd;
  logic [REQ_W-1:0] in_req;
  logic [BLK_W-1:0] in_blk;
  logic             in_acc;
  assign in_cmd = s_axis_tuser;
  assign in_req = s_axis_tdata[REQ_W-1:0];
  assign in_blk = s_axis_tdata[REQ_W+BLK_W-1:REQ_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Free list ring
  logic [OW-1:0] cell_q [LIST_DEPTH];
  logic [OW-1:0] head;
  logic [OW-1:0] tail_w;
  logic          ring_shift;
  logic          init_load;
  assign head       = cell_q[0];
  assign ring_shift = ((state_q == S_SCAN) && (step_q != CW'(LIST_DEPTH))) ||
                      (state_q == S_EDIT);
  assign init_load  = in_acc && (in_cmd == CMD_INIT);

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    cell_ctl_t     ctl;
    logic [OW-1:0] nxt;
    assign ctl.shift = ring_shift;
    assign ctl.load  = (k == 0) ? init_load : 1'b0;
    if (k == LIST_DEPTH - 1) begin : g_tail
      assign nxt = tail_w;
    end else begin : g_mid
      assign nxt = cell_q[k+1];
    end
    bfha_cell #(.WIDTH(OW)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .nxt_i  (nxt),
      .load_i ('0),
      .q_o    (cell_q[k])
    );
  end

  // Edit stream: logical position of the entry written into the tail
  logic [CW-1:0] pos;
  logic [CW-1:0] t_ext;
  assign pos   = step_q - CW'(1);
  assign t_ext = CW'(t_q);
  always_comb begin
    tail_w = head;
    if (state_q == S_EDIT) begin
      case (edit_q)
        ED_REPL: tail_w = (pos == t_ext) ? val_q : prev_q;
        ED_REM:  tail_w = (pos < t_ext) ? prev_q : head;
        ED_INS:  tail_w = (pos < t_ext) ? prev_q : ((pos == t_ext) ? val_q : prev2_q);
        default: tail_w = prev_q;
      endcase
    end
  end

  // Chunk size RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SIZE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [SIZE_W-1:0] ram_rdata;
  logic [OW-1:0]     in_chunk;
  assign in_chunk  = OW'(32'(in_blk) - 32'(HEADER_BYTES));
  assign ram_we    = ((state_q == S_WR1) && wr1_en_q) || ((state_q == S_WR2) && wr2_en_q);
  assign ram_waddr = (state_q == S_WR1) ? wr1_addr_q : wr2_addr_q;
  assign ram_wdata = (state_q == S_WR1) ? wr1_data_q : wr2_data_q;
  assign ram_raddr = (state_q == S_IDLE) ? in_chunk[AW+1:2] : head[AW+1:2];

  bfha_ram #(.WIDTH(SIZE_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Scan helpers
  logic [SIZE_W-1:0] sz;
  logic              eval;
  logic [31:0]       end_w;
  logic [31:0]       curr_end;
  logic [TW-1:0]     idx;
  logic [31:0]       hs_full;
  logic [31:0]       need_w;
  logic              head_oob;
  assign sz       = rd_oob_q ? '0 : ram_rdata;
  assign eval     = (state_q == S_SCAN) && (step_q != '0) && (step_q <= count_q) &&
                    (dec_q == FD_NONE);
  assign end_w    = 32'(chunk_q) + 32'(csz_q);
  assign curr_end = 32'(dly_q) + 32'(sz);
  assign idx      = pos[TW-1:0];
  assign head_oob = 32'(head) >= 32'(HEAP_BYTES);
  assign need_w   = ((32'(in_req) + 32'd3) & ~32'd3) + 32'(HEADER_BYTES);

  always_comb begin
    if (32'(heap_bytes_q) < 32'(HEAP_FLOOR)) begin
      hs_full = 32'(HEAP_FLOOR);
    end else begin
      hs_full = (32'(heap_bytes_q) + 32'd3) & ~32'd3;
    end
    if (hs_full > 32'(CAP)) begin
      hs_full = 32'(CAP);
    end
  end

  // Decision helpers
  logic [31:0]       off_need;
  logic [SIZE_W-1:0] csz2;
  logic [CW-1:0]     ins_pos;
  assign off_need = 32'(boff_q) + 32'(need_q);
  assign csz2     = SIZE_W'(32'(csz_q) + 32'(send_q));
  assign ins_pos  = (dec_q == FD_INS) ? t_ext : count_q;

  // Sequencer, list control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      edit_q       <= ED_NONE;
      dec_q        <= FD_NONE;
      heap_bytes_q <= CFG_RESET;
      heap_size_q  <= '0;
      count_q      <= '0;
      step_q       <= '0;
      cap_q        <= 1'b0;
      mnext_q      <= 1'b0;
      wr1_en_q     <= 1'b0;
      wr2_en_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        heap_bytes_q <= cfg_wdata_i;
      end
      // drop the result once taken, unless a new one replaces it this cycle
      if (out_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q    <= in_cmd;
            dec_q    <= FD_NONE;
            edit_q   <= ED_NONE;
            mnext_q  <= 1'b0;
            cap_q    <= 1'b0;
            wr1_en_q <= (in_cmd == CMD_INIT);
            wr2_en_q <= 1'b0;
            pay_q    <= '0;
            step_q   <= '0;
            case (in_cmd)
              CMD_INIT: begin
                heap_size_q <= hs_full[HSW-1:0];
                count_q     <= CW'(1);
                wr1_addr_q  <= '0;
                wr1_data_q  <= hs_full[SIZE_W-1:0];
                status_q    <= ST_OK;
                state_q     <= S_WR1;
              end
              CMD_ALLOC: begin
                need_q <= need_w[NW-1:0];
                best_q <= '0;
                t_q    <= '0;
                if ((in_req == '0) || (count_q == '0)) begin
                  status_q <= ST_FAIL;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              CMD_FREE: begin
                chunk_q <= in_chunk;
                if ((32'(in_blk) >= 32'(heap_size_q)) ||
                    (32'(in_blk) < 32'(HEADER_BYTES))) begin
                  status_q <= ST_RANGE;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_SZRD;
                end
              end
              default: begin
                status_q <= ST_FAIL;
                state_q  <= S_FIN;
              end
            endcase
          end
        end

        S_SZRD: begin
          csz_q   <= ram_rdata;
          state_q <= S_SCAN;
        end

        S_SCAN: begin
          dly_q    <= head;
          rd_oob_q <= head_oob;
          if (step_q == CW'(LIST_DEPTH)) begin
            state_q <= S_DECIDE;
          end else begin
            step_q <= step_q + CW'(1);
          end
          if (cap_q) begin
            send_q <= sz;
            cap_q  <= 1'b0;
          end
          if (eval) begin
            if (cmd_q == CMD_ALLOC) begin
              if ((32'(sz) >= 32'(need_q)) && ((best_q == '0) || (sz < best_q))) begin
                best_q <= sz;
                t_q    <= idx;
                boff_q <= dly_q;
              end
            end else if (curr_end == 32'(chunk_q)) begin
              // chunk follows a free chunk: merge backwards, maybe forwards too
              dec_q   <= FD_PREV;
              t_q     <= idx;
              val_q   <= dly_q;
              cs_q    <= sz;
              mnext_q <= (step_q < count_q) && (32'(head) == end_w);
              cap_q   <= (step_q < count_q) && (32'(head) == end_w);
            end else if (32'(dly_q) == end_w) begin
              dec_q <= FD_NEXT;
              t_q   <= idx;
              cs_q  <= sz;
            end else if (32'(dly_q) > end_w) begin
              dec_q <= FD_INS;
              t_q   <= idx;
            end
          end
        end

        S_DECIDE: begin
          step_q <= '0;
          if (cmd_q == CMD_ALLOC) begin
            if (best_q == '0) begin
              status_q <= ST_FAIL;
              state_q  <= S_WR1;
            end else begin
              status_q <= ST_OK;
              pay_q    <= RES_W'(32'(boff_q) + 32'(HEADER_BYTES));
              state_q  <= S_EDIT;
              if (32'(best_q) <= 32'(need_q) + 32'(MIN_SPLIT_BYTES)) begin
                edit_q  <= ED_REM;
                count_q <= count_q - CW'(1);
              end else begin
                // split: tail piece stays free, head piece goes out
                edit_q     <= ED_REPL;
                val_q      <= OW'(off_need);
                wr1_en_q   <= off_need < 32'(HEAP_BYTES);
                wr1_addr_q <= off_need[AW+1:2];
                wr1_data_q <= SIZE_W'(32'(best_q) - 32'(need_q));
                wr2_en_q   <= 32'(boff_q) < 32'(HEAP_BYTES);
                wr2_addr_q <= boff_q[AW+1:2];
                wr2_data_q <= need_q[SIZE_W-1:0];
              end
            end
          end else begin
            case (dec_q)
              FD_PREV: begin
                status_q <= ST_OK;
                if (mnext_q) begin
                  wr1_en_q   <= 1'b1;
                  wr1_addr_q <= chunk_q[AW+1:2];
                  wr1_data_q <= csz2;
                  wr2_en_q   <= 32'(val_q) < 32'(HEAP_BYTES);
                  wr2_addr_q <= val_q[AW+1:2];
                  wr2_data_q <= SIZE_W'(32'(cs_q) + 32'(csz2));
                  edit_q     <= ED_REM;
                  t_q        <= t_q + TW'(1);
                  count_q    <= count_q - CW'(1);
                  state_q    <= S_EDIT;
                end else begin
                  wr1_en_q   <= 32'(val_q) < 32'(HEAP_BYTES);
                  wr1_addr_q <= val_q[AW+1:2];
                  wr1_data_q <= SIZE_W'(32'(cs_q) + 32'(csz_q));
                  state_q    <= S_WR1;
                end
              end
              FD_NEXT: begin
                status_q   <= ST_OK;
                wr1_en_q   <= 1'b1;
                wr1_addr_q <= chunk_q[AW+1:2];
                wr1_data_q <= SIZE_W'(32'(csz_q) + 32'(cs_q));
                edit_q     <= ED_REPL;
                val_q      <= chunk_q;
                state_q    <= S_EDIT;
              end
              default: begin
                if (count_q >= CW'(LIST_DEPTH)) begin
                  status_q <= ST_FAIL;
                  state_q  <= S_WR1;
                end else begin
                  status_q <= ST_OK;
                  edit_q   <= ED_INS;
                  t_q      <= ins_pos[TW-1:0];
                  val_q    <= chunk_q;
                  count_q  <= count_q + CW'(1);
                  state_q  <= S_EDIT;
                end
              end
            endcase
          end
        end

        S_EDIT: begin
          prev_q  <= head;
          prev2_q <= prev_q;
          step_q  <= step_q + CW'(1);
          if (step_q == CW'(LIST_DEPTH)) begin
            state_q <= S_WR1;
          end
        end

        S_WR1: begin
          state_q <= S_WR2;
        end

        S_WR2: begin
          state_q <= S_FIN;
        end

        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_pay_q    <= (status_q == ST_OK) ? pay_q : '0;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pay_q, out_status_q};

`ifndef ASSERT_OFF
  // Free list never holds more entries than cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(LIST_DEPTH))
    else $error("free list count beyond ring depth");

  // A failed result carries a zero offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)) |-> (m_axis_tdata[15:2] == '0))
    else $error("non-zero offset on failed result");

  // An accepted item keeps the block busy in the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken twice in a row");
`endif

endmodule

/* rtl/bfha_ram.sv */
`timescale 1ns / 1ps
module bfha_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/bfha_cell.sv */
`timescale 1ns / 1ps
module bfha_cell
  import bfha_pkg::*;
#(
  parameter int WIDTH = 17
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [WIDTH-1:0] nxt_i,
  input  logic [WIDTH-1:0] load_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] val_q;

  // Load a fresh value or take the neighbour's entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      val_q <= load_i;
    end else if (ctl_i.shift) begin
      val_q <= nxt_i;
    end
  end

  assign q_o = val_q;

endmodule
